FILE: hdl/tea_pkg.sv
// shared types, constants and round function for the tea block cipher
package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NSTAGES   = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NKEYS     = 4;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // direction codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 8'd3;

  typedef logic [WORD_W-1:0] word_t;

  // 128-bit key, word 0 in the lowest index
  typedef word_t [NKEYS-1:0] key_t;

  // one block in flight plus its direction
  typedef struct packed {
    logic  mode;
    word_t first;
    word_t second;
  } blk_t;

  function automatic word_t mix(word_t x, word_t sum, word_t ka, word_t kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  // running sum after mult additions of delta, wrapped to 32 bits
  function automatic word_t sum_of(int unsigned mult);
    logic [63:0] p;
    p = 64'(mult) * 64'(DELTA);
    return p[WORD_W-1:0];
  endfunction

endpackage

FILE: hdl/tea_key_regs.sv
// key configuration registers of the tea block cipher
module tea_key_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]     cfg_data,
  output tea_pkg::key_t                  key
);

  tea_pkg::key_t key_r;
  tea_pkg::key_t key_nxt;

  assign cfg_ready = 1'b1;
  assign key       = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tea_pkg::REG_KEY_WORD0: key_nxt[0] = cfg_data;
        tea_pkg::REG_KEY_WORD1: key_nxt[1] = cfg_data;
        tea_pkg::REG_KEY_WORD2: key_nxt[2] = cfg_data;
        tea_pkg::REG_KEY_WORD3: key_nxt[3] = cfg_data;
        default:                key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule

FILE: hdl/tea_half_round.sv
// one pipeline stage: half of a tea round, one word updated
module tea_half_round (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        odd_stage,
  input  logic [tea_pkg::WORD_W-1:0]  sum_enc,
  input  logic [tea_pkg::WORD_W-1:0]  sum_dec,
  input  tea_pkg::key_t               key,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tea_pkg::blk_t               in_blk,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tea_pkg::blk_t               out_blk
);

  logic                       valid_r;
  tea_pkg::blk_t              blk_r;
  tea_pkg::blk_t              blk_nxt;
  logic                       upd_first;
  logic [tea_pkg::WORD_W-1:0] src;
  logic [tea_pkg::WORD_W-1:0] sum;
  logic [tea_pkg::WORD_W-1:0] ka;
  logic [tea_pkg::WORD_W-1:0] kb;
  logic [tea_pkg::WORD_W-1:0] m;

  // encrypt: even stage updates first, odd updates second; decrypt is mirrored
  assign upd_first = (odd_stage == in_blk.mode);
  assign src       = upd_first ? in_blk.second : in_blk.first;
  assign sum       = (in_blk.mode == tea_pkg::MODE_DEC) ? sum_dec : sum_enc;
  assign ka        = upd_first ? key[0] : key[2];
  assign kb        = upd_first ? key[1] : key[3];
  assign m         = tea_pkg::mix(src, sum, ka, kb);

  always_comb begin
    blk_nxt = in_blk;
    if (upd_first) begin
      blk_nxt.first  = (in_blk.mode == tea_pkg::MODE_DEC) ? in_blk.first - m
                                                          : in_blk.first + m;
    end else begin
      blk_nxt.second = (in_blk.mode == tea_pkg::MODE_DEC) ? in_blk.second - m
                                                          : in_blk.second + m;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_blk   = blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

FILE: hdl/tea_block_cipher.sv
// top level of the tea block cipher: key registers and half-round pipeline
//
// Encrypts (tuser 0) or decrypts (tuser 1) one 64-bit block per transaction
// with the Tiny Encryption Algorithm, 32 rounds, under the 128-bit key held in
// configuration registers 0..3 (key words 0..3, reset to zero; writes to other
// indexes are dropped). The datapath is a chain of 64 register stages, each
// computing one half round (one mix function and one 32-bit add or subtract),
// so a new block is taken in every cycle unless all stages are full and the
// output side is stalled. A block moves through the stage registers in order,
// and the last stage register drives the output. Each stage holds its block
// until the next stage can take it, so bubbles close up and the input keeps
// accepting while a finished result waits, until all 64 stages are full. The
// key is read live by every stage: change it only when no block is in flight.
module tea_block_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // second_word, first_word
  input  logic                           in_tuser,   // mode
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // out_second_word, out_first_word
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]     cfg_data
);

  tea_pkg::key_t                  key;
  logic [tea_pkg::NSTAGES:0]      vld;
  logic [tea_pkg::NSTAGES:0]      rdy;
  tea_pkg::blk_t                  blk [tea_pkg::NSTAGES+1];

  tea_key_regs u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // entry into stage 0
  assign vld[0]        = in_tvalid;
  assign in_tready     = rdy[0];
  assign blk[0].mode   = in_tuser;
  assign blk[0].first  = in_tdata[31:0];
  assign blk[0].second = in_tdata[63:32];

  for (genvar s = 0; s < tea_pkg::NSTAGES; s++) begin : g_stage
    // round number of this stage; encrypt counts sum up, decrypt counts down
    localparam int unsigned RND = s / 2;
    localparam logic [tea_pkg::WORD_W-1:0] SUM_ENC = tea_pkg::sum_of(RND + 1);
    localparam logic [tea_pkg::WORD_W-1:0] SUM_DEC = tea_pkg::sum_of(tea_pkg::ROUNDS - RND);
    localparam logic ODD = 1'(s % 2);

    tea_half_round u_half (
      .clk       (clk),
      .rst_n     (rst_n),
      .odd_stage (ODD),
      .sum_enc   (SUM_ENC),
      .sum_dec   (SUM_DEC),
      .key       (key),
      .in_valid  (vld[s]),
      .in_ready  (rdy[s]),
      .in_blk    (blk[s]),
      .out_valid (vld[s+1]),
      .out_ready (rdy[s+1]),
      .out_blk   (blk[s+1])
    );
  end

  // last stage register is the output register
  assign rdy[tea_pkg::NSTAGES] = out_tready;
  assign out_tvalid            = vld[tea_pkg::NSTAGES];
  assign out_tdata             = {blk[tea_pkg::NSTAGES].second, blk[tea_pkg::NSTAGES].first};

endmodule

FILE: hdl/tea_checker.sv
// port-level checks of the tea block cipher, bound to the top level
module tea_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

  // when the output side is free, the whole pipeline moves and the input is ready
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled although output side is free");

  // key writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (.*);
